// File: sv/utf8s_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and helpers of the UTF-8 byte sanitiser.
package utf8s_pkg;

	// Continuation bytes have the form 10xxxxxx.
	localparam logic [7:0] CONT_MASK = 8'hC0;
	localparam logic [7:0] CONT_TAG  = 8'h80;

	// Lead byte tags: 110xxxxx, 1110xxxx and 11110xxx.
	localparam logic [2:0] LEAD2_TAG = 3'h6;
	localparam logic [3:0] LEAD3_TAG = 4'hE;
	localparam logic [4:0] LEAD4_TAG = 5'h1E;

	// Replacement character U+FFFD, encoded as EF BF BD.
	localparam logic [7:0] REPL_B0 = 8'hEF;
	localparam logic [7:0] REPL_B1 = 8'hBF;
	localparam logic [7:0] REPL_B2 = 8'hBD;

	// Phase of the last byte within one replacement character.
	localparam logic [1:0] REPL_PH_LAST = 2'd2;

	// Work that one input item leaves for the output side: a number of
	// replacement characters followed by a number of literal bytes.
	typedef struct packed {
		logic [3:0][7:0] lit;
		logic [2:0]      nlit;
		logic [2:0]      nrep;
		logic            text_end;
	} desc_t;

	// Sequence state, exported for checking.
	typedef struct packed {
		logic [1:0] held_count;
		logic [2:0] seq_len;
	} status_t;

	// One byte of the replacement character, chosen by its phase.
	function automatic logic [7:0] repl_byte(input logic [1:0] ph);
		logic [7:0] r;
		case (ph)
			2'd0: r = REPL_B0;
			2'd1: r = REPL_B1;
			2'd2: r = REPL_B2;
			default: r = REPL_B2;
		endcase
		return r;
	endfunction

endpackage

// File: sv/utf8s_in_if.sv
`timescale 1ns / 1ps
// Channel that carries raw text bytes into the sanitiser.
interface utf8s_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       text_last;

	modport source (output valid, output in_byte, output text_last, input ready);
	modport sink (input valid, input in_byte, input text_last, output ready);
endinterface

// File: sv/utf8s_out_if.sv
`timescale 1ns / 1ps
// Channel that carries sanitised text bytes out of the sanitiser.
interface utf8s_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_last;
	logic       text_end;

	modport source (output valid, output out_byte, output run_last, output text_end,
		input ready);
	modport sink (input valid, input out_byte, input run_last, input text_end,
		output ready);
endinterface

// File: sv/utf8s_decode.sv
`timescale 1ns / 1ps
// Sequence tracker: holds open UTF-8 sequences and works out the output of each item.
module utf8s_decode import utf8s_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] in_byte,
	input  logic       text_last,
	output desc_t      desc,
	output logic       has_result,
	output status_t    status
);

	logic [7:0] held_q [3];
	logic [1:0] hc_q;
	logic [2:0] sl_q;

	logic [1:0] nhc;
	logic [2:0] nsl;
	logic       wr_en;
	logic [1:0] wr_idx;
	logic       is_cont;
	logic [2:0] lead_n;
	logic       do_fresh;
	logic [2:0] nrep_base;

	// Classify the incoming byte.
	always_comb begin
		is_cont = (in_byte & CONT_MASK) == CONT_TAG;
		if (in_byte[7:5] == LEAD2_TAG) begin
			lead_n = 3'd2;
		end else if (in_byte[7:4] == LEAD3_TAG) begin
			lead_n = 3'd3;
		end else if (in_byte[7:3] == LEAD4_TAG) begin
			lead_n = 3'd4;
		end else begin
			lead_n = 3'd0;
		end
	end

	// Decide the results of this item and the next sequence state.
	always_comb begin
		desc          = '0;
		desc.text_end = text_last;
		nhc           = hc_q;
		nsl           = sl_q;
		wr_en         = 1'b0;
		wr_idx        = 2'd0;
		do_fresh      = 1'b0;
		nrep_base     = 3'd0;
		if (hc_q != 2'd0) begin
			if (is_cont) begin
				if ({1'b0, hc_q} + 3'd1 == sl_q) begin
					// Sequence complete: release the held bytes and this one.
					desc.lit[0] = held_q[0];
					desc.lit[1] = (hc_q > 2'd1) ? held_q[1] : in_byte;
					desc.lit[2] = (hc_q > 2'd2) ? held_q[2] : in_byte;
					desc.lit[3] = in_byte;
					desc.nlit   = {1'b0, hc_q} + 3'd1;
					nhc         = 2'd0;
					nsl         = 3'd0;
				end else if (text_last || hc_q == 2'd3) begin
					// Text ends inside the sequence: replace every byte of it.
					desc.nrep = {1'b0, hc_q} + 3'd1;
					nhc       = 2'd0;
					nsl       = 3'd0;
				end else begin
					wr_en  = 1'b1;
					wr_idx = hc_q;
					nhc    = hc_q + 2'd1;
				end
			end else begin
				// Broken sequence: replace the held bytes, then take the byte afresh.
				nrep_base = {1'b0, hc_q};
				nhc       = 2'd0;
				nsl       = 3'd0;
				do_fresh  = 1'b1;
			end
		end else begin
			do_fresh = 1'b1;
		end

		// A byte seen with nothing held.
		if (do_fresh) begin
			desc.nrep = nrep_base;
			if (!in_byte[7]) begin
				desc.lit[0] = in_byte;
				desc.nlit   = 3'd1;
			end else if (lead_n == 3'd0 || text_last) begin
				desc.nrep = nrep_base + 3'd1;
			end else begin
				wr_en  = 1'b1;
				wr_idx = 2'd0;
				nhc    = 2'd1;
				nsl    = lead_n;
			end
		end
	end

	assign has_result        = (desc.nrep != 3'd0) || (desc.nlit != 3'd0);
	assign status.held_count = hc_q;
	assign status.seq_len    = sl_q;

	// Sequence counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hc_q <= 2'd0;
			sl_q <= 3'd0;
		end else if (accept) begin
			hc_q <= nhc;
			sl_q <= nsl;
		end
	end

	// Held bytes of the open sequence.
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			if (accept && wr_en && wr_idx == 2'(i)) begin
				held_q[i] <= in_byte;
			end
		end
	end

endmodule

// File: sv/utf8s_emit.sv
`timescale 1ns / 1ps
// Output side: holds one item's pending results and sends them a byte at a time.
module utf8s_emit import utf8s_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  desc_t       desc_in,
	output logic        take_ok,
	utf8s_out_if.source clean
);

	desc_t      desc_s1;
	logic       desc_v_s1;
	logic [2:0] rep_q;
	logic [1:0] ph_q;
	logic [2:0] lit_q;
	logic       out_v_q;
	logic [7:0] out_byte_q;
	logic       run_last_q;
	logic       text_end_q;

	logic       out_free;
	logic       emit;
	logic       in_rep;
	logic       final_b;
	logic [7:0] cur_byte;

	// Pick the next byte and tell whether it closes the item.
	always_comb begin
		out_free = !out_v_q || clean.ready;
		emit     = desc_v_s1 && out_free;
		in_rep   = rep_q < desc_s1.nrep;
		if (in_rep) begin
			cur_byte = repl_byte(ph_q);
			final_b  = (ph_q == REPL_PH_LAST) && (rep_q + 3'd1 == desc_s1.nrep)
				&& (desc_s1.nlit == 3'd0);
		end else begin
			cur_byte = desc_s1.lit[lit_q[1:0]];
			final_b  = (lit_q + 3'd1 == desc_s1.nlit);
		end
		take_ok = !desc_v_s1 || (emit && final_b);
	end

	// Control: pending item, position within it, and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			desc_v_s1 <= 1'b0;
			out_v_q   <= 1'b0;
			rep_q     <= 3'd0;
			ph_q      <= 2'd0;
			lit_q     <= 3'd0;
		end else begin
			if (emit) begin
				out_v_q <= 1'b1;
			end else if (clean.ready) begin
				out_v_q <= 1'b0;
			end
			if (push) begin
				desc_v_s1 <= 1'b1;
				rep_q     <= 3'd0;
				ph_q      <= 2'd0;
				lit_q     <= 3'd0;
			end else if (emit && final_b) begin
				desc_v_s1 <= 1'b0;
				rep_q     <= 3'd0;
				ph_q      <= 2'd0;
				lit_q     <= 3'd0;
			end else if (emit) begin
				if (in_rep) begin
					if (ph_q == REPL_PH_LAST) begin
						ph_q  <= 2'd0;
						rep_q <= rep_q + 3'd1;
					end else begin
						ph_q <= ph_q + 2'd1;
					end
				end else begin
					lit_q <= lit_q + 3'd1;
				end
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (push) begin
			desc_s1 <= desc_in;
		end
		if (emit) begin
			out_byte_q <= cur_byte;
			run_last_q <= final_b;
			text_end_q <= final_b && desc_s1.text_end;
		end
	end

	assign clean.valid    = out_v_q;
	assign clean.out_byte = out_byte_q;
	assign clean.run_last = run_last_q;
	assign clean.text_end = text_end_q;

endmodule

// File: sv/utf8_byte_sanitizer.sv
`timescale 1ns / 1ps
// UTF-8 byte sanitiser: top level joining the sequence tracker and the output side.
//
// Usage:
// Raw text enters on the raw channel one byte per item, with text_last on the
// final byte of a text. Cleaned bytes leave on the clean channel, one per item;
// run_last marks the final result caused by one input item and text_end the
// final byte of a whole text. Well formed sequences pass unchanged; bad bytes
// and broken sequences come out as EF BF BD.
// The results of an accepted item are registered in the pending register and
// sent from there through the output register; the next item is taken as the
// last result of the current one is sent. An input item yields 0 to 12 results;
// while the receiver is ready the output register sends one byte per cycle, and
// items with at most one result flow at one item per cycle. A held lead or
// continuation byte yields nothing until its sequence completes or breaks.
// Reset empties both registers and forgets any open sequence. When the receiver
// stalls, the output byte holds; one more item's results wait in the pending
// register, and raw.ready falls once that register cannot be freed.
module utf8_byte_sanitizer import utf8s_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	utf8s_in_if.sink   raw,
	utf8s_out_if.source clean
);

	desc_t   desc;
	logic    has_result;
	status_t status;
	logic    take_ok;
	logic    accept;

	// An item is taken whenever the pending register is free or frees now.
	assign raw.ready = take_ok;
	assign accept    = raw.valid && take_ok;

	utf8s_decode u_decode (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.in_byte    (raw.in_byte),
		.text_last  (raw.text_last),
		.desc       (desc),
		.has_result (has_result),
		.status     (status)
	);

	utf8s_emit u_emit (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (accept && has_result),
		.desc_in (desc),
		.take_ok (take_ok),
		.clean   (clean)
	);

	// An open sequence always has fewer bytes held than its length.
	a_held_below_len: assert property (@(posedge clk) disable iff (!arst_n)
		(status.held_count != 2'd0) |-> ({1'b0, status.held_count} < status.seq_len))
		else $error("held byte count reached the sequence length");

	// With nothing held there is no open sequence.
	a_idle_no_len: assert property (@(posedge clk) disable iff (!arst_n)
		(status.held_count == 2'd0) |-> (status.seq_len == 3'd0))
		else $error("sequence length set with no held bytes");

	// The end of a text flushes every held byte.
	a_last_flushes: assert property (@(posedge clk) disable iff (!arst_n)
		(raw.valid && raw.ready && raw.text_last) |=> (status.held_count == 2'd0))
		else $error("bytes still held after end of text");

	// The end of a text is always the last result of its item.
	a_end_is_run_last: assert property (@(posedge clk) disable iff (!arst_n)
		(clean.valid && clean.text_end) |-> clean.run_last)
		else $error("text end on a result that is not the last of its item");

endmodule
